// File: rtl/plus45_phase_fir_filter_defines.svh
// Assertion macros for the +45 degree phase FIR filter.
// Used by files that check their own control logic; expects clk and rst_n in scope.
`ifndef PLUS45_PHASE_FIR_FILTER_DEFINES_SVH
`define PLUS45_PHASE_FIR_FILTER_DEFINES_SVH
`ifndef SYNTH
`define P45_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("p45fir: check failed");
`define P45_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("p45fir: check failed");
`else
`define P45_ASSERT_IMP(lbl, ante, cons)
`define P45_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/p45fir_pkg.sv
// Package for the +45 degree phase FIR filter: sizes, coefficient table, cell control.
// No dependencies.
`default_nettype none
package p45fir_pkg;
    localparam int TAP_COUNT       = 33;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS       = 16;
    localparam int ACC_SHIFT       = 16;
    localparam int IDX_BITS        = $clog2(TAP_COUNT);

    typedef logic signed [COEF_BITS-1:0] coef_t;

    localparam coef_t COEF_TABLE [TAP_COUNT] = '{
        -16'sd43,    16'sd5,      -16'sd126,   -16'sd28,
        -16'sd274,   -16'sd144,   -16'sd493,   -16'sd416,
        -16'sd771,   -16'sd960,   -16'sd1073,  -16'sd2001,
        -16'sd1349,  -16'sd4287,  -16'sd1542,  -16'sd14525,
        16'sd21550,
        16'sd14525,  -16'sd1542,  16'sd4287,   -16'sd1349,
        16'sd2001,   -16'sd1073,  16'sd960,    -16'sd771,
        16'sd416,    -16'sd493,   16'sd144,    -16'sd274,
        16'sd28,     -16'sd126,   -16'sd5,     -16'sd43
    };

    typedef struct packed {
        logic load;
        logic rotate;
    } cell_ctrl_t;
endpackage
`default_nettype wire

// File: rtl/p45fir_if.sv
// Stream interfaces for the +45 degree phase FIR filter: sample input and result output.
// Depends on p45fir_pkg.
`default_nettype none
interface p45fir_in_if import p45fir_pkg::*; #(
    parameter int W = SAMPLE_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

interface p45fir_out_if import p45fir_pkg::*; #(
    parameter int W = SAMPLE_BITS_DEF + 1
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] filtered_out;

    modport source (output valid, output filtered_out, input ready);
    modport sink (input valid, input filtered_out, output ready);
endinterface
`default_nettype wire

// File: rtl/p45fir_cell.sv
// One history cell: shifts toward older taps on load, rotates toward tap 0 during a sum.
// Depends on p45fir_pkg.
`default_nettype none
module p45fir_cell import p45fir_pkg::*; #(
    parameter int W = SAMPLE_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cell_ctrl_t          ctrl,
    input  wire logic signed [W-1:0] prev_data,
    input  wire logic signed [W-1:0] next_data,
    output logic signed [W-1:0]      data
);
    logic signed [W-1:0] data_reg;
    logic signed [W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = prev_data;
        end
        else if (ctrl.rotate)
        begin
            data_next = next_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;
endmodule
`default_nettype wire

// File: rtl/p45fir_mac.sv
// Shared multiply-accumulate: registered product, then a wide accumulator.
// Depends on p45fir_pkg.
`default_nettype none
module p45fir_mac import p45fir_pkg::*; #(
    parameter int W     = SAMPLE_BITS_DEF,
    parameter int ACC_W = SAMPLE_BITS_DEF + COEF_BITS + IDX_BITS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                clear,
    input  wire logic                mul_en,
    input  wire logic signed [W-1:0] sample,
    input  wire coef_t               coef,
    output logic signed [ACC_W-1:0]  acc
);
    localparam int PROD_W = W + COEF_BITS;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    always_comb
    begin
        prod_next = PROD_W'(sample) * PROD_W'(coef);
        acc_next  = acc_reg;
        if (clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= mul_en;
            acc_reg      <= acc_next;
        end
    end

    assign acc = acc_reg;
endmodule
`default_nettype wire

// File: rtl/plus45_phase_fir_filter.sv
// 33-tap +45 degree phase FIR filter.
// Channels: sample_ch (sink) takes one signed sample per beat; result_ch (source)
//   gives one filtered sample per accepted sample, the tap sum shifted right by 16.
// History: a row of 33 cells, tap 0 the newest. An accepted beat shifts the row by
//   one; the sum then rotates the row once around, feeding tap 0 into one shared
//   multiply-accumulate with a registered product, one tap per cycle.
// Order: the accept, the run through all taps, a flush of the last product, then the
//   write into the output register. A new sample is taken only after the write step,
//   as the single multiplier serves every tap of the current sample in turn.
// sample_ch.ready is high only between items. A finished result waits in the output
//   register; the next sample is taken while it waits. If the receiver still holds
//   off when the following result is done, that result waits in the write step.
// Reset clears the history to zero and leaves no result pending.
// Depends on p45fir_pkg, p45fir_if, p45fir_cell, p45fir_mac and the defines header.
`default_nettype none
`include "plus45_phase_fir_filter_defines.svh"
module plus45_phase_fir_filter import p45fir_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    p45fir_in_if.sink     sample_ch,
    p45fir_out_if.source  result_ch
);
    localparam int OUT_W = SAMPLE_BITS + 1;
    localparam int ACC_W = SAMPLE_BITS + COEF_BITS + IDX_BITS;
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TAP_COUNT - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [IDX_BITS-1:0]         cnt_reg;
    logic [IDX_BITS-1:0]         cnt_next;
    logic                        out_vld_reg;
    logic                        out_vld_next;
    logic signed [OUT_W-1:0]     filtered_reg;
    logic signed [OUT_W-1:0]     filtered_next;
    logic                        accept;
    logic                        out_free;
    cell_ctrl_t                  cell_ctrl;
    logic signed [ACC_W-1:0]     acc;
    logic signed [SAMPLE_BITS-1:0] tap_data [TAP_COUNT];

    assign accept           = sample_ch.valid && sample_ch.ready;
    assign sample_ch.ready  = (state_reg == ST_IDLE);
    assign out_free         = !out_vld_reg || result_ch.ready;
    assign cell_ctrl.load   = accept;
    assign cell_ctrl.rotate = (state_reg == ST_RUN);

    for (genvar i = 0; i < TAP_COUNT; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            p45fir_cell #(.W(SAMPLE_BITS)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl),
                .prev_data (sample_ch.sample_in),
                .next_data (tap_data[1]),
                .data      (tap_data[0])
            );
        end
        else
        begin : g_body
            p45fir_cell #(.W(SAMPLE_BITS)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl),
                .prev_data (tap_data[i-1]),
                .next_data (tap_data[(i + 1) % TAP_COUNT]),
                .data      (tap_data[i])
            );
        end
    end

    p45fir_mac #(.W(SAMPLE_BITS), .ACC_W(ACC_W)) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (accept),
        .mul_en (state_reg == ST_RUN),
        .sample (tap_data[0]),
        .coef   (COEF_TABLE[cnt_reg]),
        .acc    (acc)
    );

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        out_vld_next  = out_vld_reg && !result_ch.ready;
        filtered_next = filtered_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = ST_FLUSH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    filtered_next = acc[ACC_SHIFT + SAMPLE_BITS : ACC_SHIFT];
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        filtered_reg <= filtered_next;
    end

    assign result_ch.valid        = out_vld_reg;
    assign result_ch.filtered_out = filtered_reg;

    `P45_ASSERT_NEXT(a_accept_starts_run, accept, state_reg == ST_RUN && cnt_reg == '0)
    `P45_ASSERT_NEXT(a_run_continues, state_reg == ST_RUN && cnt_reg != LAST_IDX, state_reg == ST_RUN)
    `P45_ASSERT_IMP(a_result_from_write, $rose(out_vld_reg), $past(state_reg) == ST_WRITE)
endmodule
`default_nettype wire
